@@ rtl/edmc_pkg.sv @@
// Shared types, widths and constants for the encoder distance move controller.
package edmc_pkg;

    localparam int IN_CNT_W = 32;
    localparam int TGT_W    = 20;
    localparam int TIME_W   = 32;
    localparam int ERR_W    = 20;
    localparam int DERR_W   = ERR_W + 1;
    localparam int DT_W     = 8;
    localparam int PROD_W   = ERR_W + DT_W;
    localparam int NUM_W    = 36;
    localparam int Q_W      = NUM_W - 1;
    localparam int DIV_W    = 15;
    localparam int SPEED_W  = 8;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(Q_W);

    localparam logic [TGT_W-1:0]       TARGET_RST  = '0;
    localparam logic [TIME_W-1:0]      TIMEOUT_RST = 32'd2000;
    localparam logic                   FORWARD_RST = 1'b1;

    localparam logic [TIME_W-1:0]      DT_MAX      = 32'd200;
    localparam logic [DT_W-1:0]        DT_MIN      = 8'd1;
    localparam logic [DT_W-1:0]        DT_CLAMP    = 8'd200;
    localparam logic signed [NUM_W-1:0] KP_GAIN    = 36'sd45;
    localparam logic signed [NUM_W-1:0] KD_GAIN    = 36'sd9000;
    localparam logic [DIV_W-1:0]       DT_SCALE    = 15'd100;
    localparam logic [Q_W-1:0]         SPEED_MAX_Q = 35'd150;
    localparam logic [SPEED_W-1:0]     SPEED_MAX   = 8'd150;
    localparam logic [SPEED_W-1:0]     SPEED_MIN   = 8'd50;
    localparam logic [ERR_W-1:0]       ERR_FLOOR   = 20'd20;

    typedef enum logic [1:0] {
        ST_RUNNING   = 2'd0,
        ST_REACHED   = 2'd1,
        ST_TIMEOUT   = 2'd2,
        ST_START_ACK = 2'd3
    } edmc_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET    = 2'd0,
        REG_TIMEOUT   = 2'd1,
        REG_DIRECTION = 2'd2
    } edmc_reg_idx_t;

    typedef struct packed {
        logic load_in;
        logic snap;
        logic delta;
        logic mag;
        logic avg;
        logic check;
        logic prod;
        logic num;
        logic div_step;
        logic load_out;
    } edmc_cmd_t;

    typedef struct packed {
        logic is_update;
        logic halt;
        logic out_free;
    } edmc_stat_t;

endpackage

@@ rtl/edmc_ctrl.sv @@
// Sequencer that steps one transaction through the datapath.
module edmc_ctrl
    import edmc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  edmc_stat_t stat,
    output edmc_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DELTA  = 10'b00_0000_0010,
        S_SNAP   = 10'b00_0000_0100,
        S_MAG    = 10'b00_0000_1000,
        S_AVG    = 10'b00_0001_0000,
        S_CHECK  = 10'b00_0010_0000,
        S_PROD   = 10'b00_0100_0000,
        S_NUM    = 10'b00_1000_0000,
        S_DIV    = 10'b01_0000_0000,
        S_RESULT = 10'b10_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DELTA;
                end
            end
            S_DELTA: begin
                cmd.delta  = 1'b1;
                state_next = stat.is_update ? S_MAG : S_SNAP;
            end
            S_SNAP: begin
                cmd.snap   = 1'b1;
                state_next = S_RESULT;
            end
            S_MAG: begin
                cmd.mag    = 1'b1;
                state_next = S_AVG;
            end
            S_AVG: begin
                cmd.avg    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = stat.halt ? S_RESULT : S_PROD;
            end
            S_PROD: begin
                cmd.prod   = 1'b1;
                state_next = S_NUM;
            end
            S_NUM: begin
                cmd.num    = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(Q_W - 1)) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

@@ rtl/edmc_datapath.sv @@
// Datapath: configuration, move snapshot, travel error, PD numerator and divider.
module edmc_datapath
    import edmc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_wr_data,
    input  logic                        s_cmd,
    input  logic signed [IN_CNT_W-1:0]  s_right_count,
    input  logic signed [IN_CNT_W-1:0]  s_left_count,
    input  logic [TIME_W-1:0]           s_now_ms,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [SPEED_W-1:0]          m_speed,
    output logic                        m_direction,
    input  edmc_cmd_t                   cmd,
    output edmc_stat_t                  stat
);

    localparam int CW    = COUNT_WIDTH;
    localparam int CMP_W = (CW > TGT_W) ? CW : TGT_W;

    logic [TGT_W-1:0]   target_reg;
    logic [TIME_W-1:0]  timeout_reg;
    logic               forward_reg;

    logic [CW-1:0]      start_right_reg, start_left_reg;
    logic [TIME_W-1:0]  start_time_reg, last_time_reg;
    logic [ERR_W-1:0]   last_error_reg;

    logic               cmd_in_reg;
    logic [CW-1:0]      right_reg, left_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [CW-1:0]      dr_reg, dl_reg, ar_reg, al_reg, avg_reg;
    logic [ERR_W-1:0]   err_reg;
    logic [DT_W-1:0]    dt_reg;
    edmc_status_t       code_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic signed [DERR_W-1:0] derr_reg;
    logic [DIV_W-1:0]   divisor_reg, rem_reg;
    logic [Q_W-1:0]     quo_reg;
    logic               neg_reg;

    logic               m_valid_reg;
    edmc_status_t       m_status_reg;
    logic [SPEED_W-1:0] m_speed_reg;
    logic               m_direction_reg;

    logic [CW:0]        sum;
    logic [CMP_W-1:0]   avg_ext, target_ext, err_full;
    logic               reached, timed_out;
    logic [TIME_W-1:0]  elapsed, dt_raw;
    logic [DT_W-1:0]    dt_next;
    logic signed [NUM_W-1:0] num;
    logic [DIV_W+1:0]   trial;
    logic [SPEED_W-1:0] sat, speed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= TARGET_RST;
            timeout_reg <= TIMEOUT_RST;
            forward_reg <= FORWARD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TARGET:    target_reg  <= cfg_wr_data[TGT_W-1:0];
                REG_TIMEOUT:   timeout_reg <= cfg_wr_data[TIME_W-1:0];
                REG_DIRECTION: forward_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign sum        = {1'b0, ar_reg} + {1'b0, al_reg};
    assign avg_ext    = CMP_W'(avg_reg);
    assign target_ext = CMP_W'(target_reg);
    assign reached    = (avg_ext >= target_ext);
    assign err_full   = target_ext - avg_ext;
    assign elapsed    = now_reg - start_time_reg;
    assign timed_out  = (elapsed > timeout_reg);
    assign dt_raw     = now_reg - last_time_reg;

    always_comb begin
        if (dt_raw == '0) begin
            dt_next = DT_MIN;
        end else if (dt_raw > DT_MAX) begin
            dt_next = DT_CLAMP;
        end else begin
            dt_next = dt_raw[DT_W-1:0];
        end
    end

    assign num = signed'(NUM_W'(prod_reg)) * KP_GAIN + NUM_W'(derr_reg) * KD_GAIN;
    assign trial = {1'b0, rem_reg, quo_reg[Q_W-1]} - {2'b00, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_right_reg <= '0;
            start_left_reg  <= '0;
            start_time_reg  <= '0;
            last_time_reg   <= '0;
            last_error_reg  <= '0;
        end else if (cmd.snap) begin
            start_right_reg <= right_reg;
            start_left_reg  <= left_reg;
            start_time_reg  <= now_reg;
            last_time_reg   <= now_reg;
            last_error_reg  <= '0;
        end else if (cmd.prod) begin
            last_time_reg   <= now_reg;
            last_error_reg  <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_in_reg <= s_cmd;
            right_reg  <= CW'(s_right_count);
            left_reg   <= CW'(s_left_count);
            now_reg    <= s_now_ms;
        end
        if (cmd.delta) begin
            dr_reg <= right_reg - start_right_reg;
            dl_reg <= left_reg - start_left_reg;
        end
        if (cmd.mag) begin
            ar_reg <= dr_reg[CW-1] ? (~dr_reg + 1'b1) : dr_reg;
            al_reg <= dl_reg[CW-1] ? (~dl_reg + 1'b1) : dl_reg;
        end
        if (cmd.avg) begin
            avg_reg <= sum[CW:1];
        end
        if (cmd.snap) begin
            code_reg <= ST_START_ACK;
        end
        if (cmd.check) begin
            err_reg <= err_full[ERR_W-1:0];
            dt_reg  <= dt_next;
            if (reached) begin
                code_reg <= ST_REACHED;
            end else if (timed_out) begin
                code_reg <= ST_TIMEOUT;
            end else begin
                code_reg <= ST_RUNNING;
            end
        end
        if (cmd.prod) begin
            prod_reg <= PROD_W'(err_reg) * PROD_W'(dt_reg);
            derr_reg <= signed'({1'b0, err_reg}) - signed'({1'b0, last_error_reg});
        end
        if (cmd.num) begin
            quo_reg     <= num[Q_W-1:0];
            neg_reg     <= num[NUM_W-1];
            rem_reg     <= '0;
            divisor_reg <= DIV_W'(dt_reg) * DT_SCALE;
        end
        if (cmd.div_step) begin
            if (!trial[DIV_W+1]) begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[Q_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[DIV_W-2:0], quo_reg[Q_W-1]};
                quo_reg <= {quo_reg[Q_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (neg_reg) begin
            sat = '0;
        end else if (quo_reg > SPEED_MAX_Q) begin
            sat = SPEED_MAX;
        end else begin
            sat = quo_reg[SPEED_W-1:0];
        end
        if (code_reg != ST_RUNNING) begin
            speed = '0;
        end else if ((sat < SPEED_MIN) && (err_reg > ERR_FLOOR)) begin
            speed = SPEED_MIN;
        end else begin
            speed = sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg    <= code_reg;
            m_speed_reg     <= speed;
            m_direction_reg <= forward_reg;
        end
    end

    assign stat.is_update = cmd_in_reg;
    assign stat.halt      = reached || timed_out;
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_speed     = m_speed_reg;
    assign m_direction = m_direction_reg;

endmodule

@@ rtl/encoder_distance_move_controller_core.sv @@
// Encoder distance move controller: start/update transactions in, status and PD speed out.
// A start transaction (cmd 0) snapshots both wheel counts and the time and answers
// "start acknowledged" after its delta and snapshot steps. An update transaction (cmd 1)
// measures travel, checks completion and timeout, and when still running divides the PD
// numerator by 100*dt in a restoring divider that retires one quotient bit per cycle; a
// running update passes the delta, magnitude, average, check, product and numerator steps
// and the divider steps to its result, while completion and timeout answers go to the
// result after the check step. One transaction is in flight at a time and the next is taken
// the cycle after the result is loaded. The result sits in an output register, so a new
// transaction is taken while it waits; that transaction holds at its result step until the
// output register is free. Configuration writes are taken at any time and must only be
// issued while idle.
module encoder_distance_move_controller_core
    import edmc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_cmd,
    input  logic signed [IN_CNT_W-1:0]  s_right_count,
    input  logic signed [IN_CNT_W-1:0]  s_left_count,
    input  logic [TIME_W-1:0]           s_now_ms,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [SPEED_W-1:0]          m_speed,
    output logic                        m_direction
);

    edmc_cmd_t  cmd;
    edmc_stat_t stat;

    edmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    edmc_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_cmd         (s_cmd),
        .s_right_count (s_right_count),
        .s_left_count  (s_left_count),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_speed       (m_speed),
        .m_direction   (m_direction),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

@@ rtl/edmc_checker.sv @@
// Port-level checks for the encoder distance move controller, bound to the top level.
module edmc_checker
    import edmc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic [SPEED_W-1:0] m_speed
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before it was taken");

    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_speed <= SPEED_MAX))
        else $error("speed above limit");

    a_stop_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_RUNNING)) |-> (m_speed == '0))
        else $error("nonzero speed on a stopped or start result");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction taken while one is in flight");

endmodule

bind encoder_distance_move_controller_core edmc_checker u_edmc_checker (.*);
